// File: src/bspline_weight_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the B-spline weight generator
// Implication checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BSPLINE_WEIGHT_GENERATOR_UNIT_ASSERT_SVH
`define BSPLINE_WEIGHT_GENERATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: src/bswg_pkg.sv
// ----------------------------------------------------------------------------
// bswg_pkg
// Widths, sequencer codes, control struct, reciprocal table and conversion
// function shared by the B-spline weight generator modules.
// ----------------------------------------------------------------------------
package bswg_pkg;

  // Block sizing.
  localparam int MAX_ORDER   = 8;
  localparam int MIN_ORDER   = 3;
  localparam int ORDER_RESET = 4;
  localparam int FRAC_BITS   = 16;
  localparam int WF          = 24;

  // Port widths.
  localparam int CFG_W  = 4;
  localparam int IDX_W  = 3;
  localparam int OUT_W  = 18;
  localparam int OUT_FB = 17;
  localparam int ONE_OUT = 1 << OUT_FB;

  // Counter widths.
  localparam int KW = $clog2(MAX_ORDER + 1);
  localparam int JW = $clog2(MAX_ORDER);

  // Datapath widths: coefficients, weights, scaled sums, reciprocals.
  localparam int CW = FRAC_BITS + $clog2(MAX_ORDER);
  localparam int WW = WF + 2;
  localparam int SW = WF + $clog2(MAX_ORDER) + 1;
  localparam int RW = WF;
  localparam int MX = (SW > CW) ? SW : CW;
  localparam int MY = (WW > RW) ? WW : RW;
  localparam int PW = MX + MY;
  localparam int AW = PW + 1;

  // Conversion of a Q.FRAC_BITS start value to Q.WF.
  localparam int TW     = FRAC_BITS + WF + 1;
  localparam int SH_L   = (WF > FRAC_BITS) ? WF - FRAC_BITS : 0;
  localparam int SH_R   = (FRAC_BITS > WF) ? FRAC_BITS - WF : 0;
  localparam int RND_SH = (SH_R > 0) ? SH_R - 1 : 0;
  localparam logic [TW-1:0] RND_R = (SH_R > 0) ? (TW'(1) << RND_SH) : '0;

  // Reciprocal scale: 1.0 in Q.WF.
  localparam longint ONE_WF = longint'(1) << WF;

  // Sequencer state codes.
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_MA   = 3'd1;
  localparam logic [ST_W-1:0] ST_MB   = 3'd2;
  localparam logic [ST_W-1:0] ST_SUM  = 3'd3;
  localparam logic [ST_W-1:0] ST_SC   = 3'd4;
  localparam logic [ST_W-1:0] ST_WB   = 3'd5;
  localparam logic [ST_W-1:0] ST_OUT  = 3'd6;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic [ST_W-1:0] state;
    logic            load;
    logic [KW-1:0]   k;
    logic [JW-1:0]   j;
    logic [KW-1:0]   nk;
    logic [JW-1:0]   nj;
    logic [JW-1:0]   oj;
  } bswg_ctrl_t;

  // Reciprocal table: round-half-up of 1/n in Q.WF.
  function automatic logic [RW-1:0] recip(input logic [KW-1:0] n);
    case (n)
      KW'(2):  recip = RW'((ONE_WF + 1) / 2);
      KW'(3):  recip = RW'((ONE_WF + 1) / 3);
      KW'(4):  recip = RW'((ONE_WF + 2) / 4);
      KW'(5):  recip = RW'((ONE_WF + 2) / 5);
      KW'(6):  recip = RW'((ONE_WF + 3) / 6);
      KW'(7):  recip = RW'((ONE_WF + 3) / 7);
      KW'(8):  recip = RW'((ONE_WF + 4) / 8);
      KW'(9):  recip = RW'((ONE_WF + 4) / 9);
      KW'(10): recip = RW'((ONE_WF + 5) / 10);
      KW'(11): recip = RW'((ONE_WF + 5) / 11);
      KW'(12): recip = RW'((ONE_WF + 6) / 12);
      KW'(13): recip = RW'((ONE_WF + 6) / 13);
      KW'(14): recip = RW'((ONE_WF + 7) / 14);
      KW'(15): recip = RW'((ONE_WF + 7) / 15);
      default: recip = '0;
    endcase
  endfunction

  // Takes a Q.FRAC_BITS value (up to 1.0) to the Q.WF working format.
  function automatic logic [WW-1:0] wf_from_frac(input logic [FRAC_BITS:0] v);
    logic [TW-1:0] t;
    t = TW'(v) << SH_L;
    t = (t + RND_R) >> SH_R;
    return WW'(t);
  endfunction

endpackage

// File: src/bswg_datapath.sv
// ----------------------------------------------------------------------------
// bswg_datapath
// Weight registers and the shared multiplier that runs the order-raising
// recursion one product at a time under control of the sequencer.
// ----------------------------------------------------------------------------
module bswg_datapath (
  input  logic                            clk,
  input  bswg_pkg::bswg_ctrl_t            ctrl,
  input  logic [bswg_pkg::FRAC_BITS-1:0]  frac,
  output logic [bswg_pkg::OUT_W-1:0]      weight_value
);
  import bswg_pkg::*;

  localparam logic [AW-1:0] RND_F   = AW'(1) << (FRAC_BITS - 1);
  localparam logic [PW-1:0] RND_W   = PW'(1) << (WF - 1);
  localparam int            OSH     = WF - OUT_FB;
  localparam logic [WW:0]   RND_O   = (WW + 1)'(1) << (OSH - 1);
  localparam logic [WW:0]   SAT_O   = (WW + 1)'(ONE_OUT);
  localparam logic [FRAC_BITS:0] ONE_F = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  logic [FRAC_BITS-1:0] f;
  logic [WW-1:0]        w [MAX_ORDER];
  logic [PW-1:0]        prod;
  logic [AW-1:0]        acc;
  logic [SW-1:0]        sreg;

  logic [KW-1:0] tk;
  logic [JW-1:0] tj;
  logic [JW-1:0] rd_idx;
  logic [WW-1:0] rd_w;
  logic          term_a;
  logic          term_b;
  logic [CW-1:0] up_coef;
  logic [CW-1:0] dn_coef;
  logic [MX-1:0] mx;
  logic [MY-1:0] my;
  logic [PW-1:0] mult;
  logic [AW-1:0] sum;
  logic [WW-1:0] w_new;
  logic [WW:0]   o_round;

  // The write-back cycle already starts the first product of the next element.
  assign tk = (ctrl.state == ST_WB) ? ctrl.nk : ctrl.k;
  assign tj = (ctrl.state == ST_WB) ? ctrl.nj : ctrl.j;

  // The lower neighbor term is absent at index zero, the own term at the top.
  assign term_a = (tj != '0);
  assign term_b = (KW'(tj) != (tk - KW'(1)));

  assign up_coef = ((CW'(tk) - CW'(1) - CW'(tj)) << FRAC_BITS) + CW'(f);
  assign dn_coef = ((CW'(tj) + CW'(1)) << FRAC_BITS) - CW'(f);

  // Single read port on the weight registers.
  always_comb begin
    case (ctrl.state)
      ST_MB:   rd_idx = tj;
      ST_OUT:  rd_idx = ctrl.oj;
      default: rd_idx = tj - JW'(1);
    endcase
  end
  assign rd_w = w[rd_idx];

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ctrl.state)
      ST_SC: begin
        mx = MX'(sreg);
        my = MY'(recip(ctrl.k - KW'(1)));
      end
      ST_MB: begin
        mx = term_b ? MX'(dn_coef) : '0;
        my = term_b ? MY'(rd_w) : '0;
      end
      default: begin
        mx = term_a ? MX'(up_coef) : '0;
        my = term_a ? MY'(rd_w) : '0;
      end
    endcase
  end
  assign mult = PW'(mx) * PW'(my);

  // Rounding of the sum of products and of the scaled weight.
  assign sum   = acc + AW'(prod);
  assign w_new = WW'((prod + RND_W) >> WF);

  // Output weight: round to Q1.17 and saturate at 1.0.
  assign o_round = ((WW + 1)'(rd_w) + RND_O) >> OSH;
  assign weight_value = (o_round > SAT_O) ? OUT_W'(SAT_O) : OUT_W'(o_round);

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      f    <= frac;
      w[0] <= wf_from_frac(ONE_F - (FRAC_BITS + 1)'(frac));
      w[1] <= wf_from_frac((FRAC_BITS + 1)'(frac));
    end
    case (ctrl.state)
      ST_MA: begin
        prod <= mult;
      end
      ST_MB: begin
        acc  <= AW'(prod) + RND_F;
        prod <= mult;
      end
      ST_SUM: begin
        sreg <= SW'(sum >> FRAC_BITS);
      end
      ST_SC: begin
        prod <= mult;
      end
      ST_WB: begin
        w[ctrl.j] <= w_new;
        prod      <= mult;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/bspline_weight_generator_unit.sv
// ----------------------------------------------------------------------------
// bspline_weight_generator_unit
// Cardinal B-spline weight generator for particle-mesh charge spreading.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/frac) takes one fractional grid
//   offset in Q0.16 per transaction. The output channel (out_valid/out_ready)
//   returns one transaction per weight: weight_index, weight_value (Q1.17,
//   saturated at 1.0) and last on the final weight of the run.
//   The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the
//   spline order; values below 3 act as 3 and values above 8 act as 8.
//   Write it only while the block is idle.
// Sequencing:
//   For order n the recursion has E = n(n+1)/2 - 3 element updates. Each one
//   uses the single shared multiplier for two products and a reciprocal
//   scale, with a round between them; the E updates are followed by n output
//   transactions. in_ready is high only while no item is in work.
// Reset and stalls:
//   rst (synchronous) returns the sequencer to idle and the order to 4.
//   A stalled receiver holds the current weight; the run resumes when
//   out_ready returns.
// ----------------------------------------------------------------------------
`include "bspline_weight_generator_unit_assert.svh"

module bspline_weight_generator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bswg_pkg::FRAC_BITS-1:0]  frac,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bswg_pkg::IDX_W-1:0]      weight_index,
  output logic [bswg_pkg::OUT_W-1:0]      weight_value,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bswg_pkg::CFG_W-1:0]      cfg_data
);
  import bswg_pkg::*;

  logic [ST_W-1:0]  state;
  logic [CFG_W-1:0] spline_order;
  logic [KW-1:0]    ord;
  logic [KW-1:0]    k;
  logic [JW-1:0]    j;
  logic [JW-1:0]    oj;

  logic [KW-1:0] ord_next;
  logic [KW-1:0] k_next;
  logic [JW-1:0] j_next;
  logic          done;
  logic          in_fire;
  logic          out_fire;
  bswg_ctrl_t    ctrl;

  // Handshakes.
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  assign weight_index = IDX_W'(oj);
  assign last         = (KW'(oj) == (ord - KW'(1)));

  // Clamp the configured order into the supported range.
  always_comb begin
    if (spline_order < CFG_W'(MIN_ORDER)) begin
      ord_next = KW'(MIN_ORDER);
    end else if (KW'(spline_order) > KW'(MAX_ORDER)) begin
      ord_next = KW'(MAX_ORDER);
    end else begin
      ord_next = KW'(spline_order);
    end
  end

  // Walk order and index: down through the indexes, then up one order.
  assign done   = (j == '0) && (k == ord);
  assign k_next = (j == '0) ? (k + KW'(1)) : k;
  assign j_next = (j == '0) ? JW'(k) : (j - JW'(1));

  // Control bundle for the datapath.
  always_comb begin
    ctrl.state = state;
    ctrl.load  = in_fire;
    ctrl.k     = k;
    ctrl.j     = j;
    ctrl.nk    = k_next;
    ctrl.nj    = j_next;
    ctrl.oj    = oj;
  end

  // Sequencer and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      spline_order <= CFG_W'(ORDER_RESET);
      ord          <= '0;
      k            <= '0;
      j            <= '0;
      oj           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        spline_order <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            ord   <= ord_next;
            k     <= KW'(MIN_ORDER);
            j     <= JW'(MIN_ORDER - 1);
            state <= ST_MA;
          end
        end
        ST_MA: begin
          state <= ST_MB;
        end
        ST_MB: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          state <= ST_SC;
        end
        ST_SC: begin
          state <= ST_WB;
        end
        ST_WB: begin
          if (done) begin
            oj    <= '0;
            state <= ST_OUT;
          end else begin
            k     <= k_next;
            j     <= j_next;
            state <= ST_MB;
          end
        end
        ST_OUT: begin
          if (out_fire) begin
            if (last) begin
              state <= ST_IDLE;
            end else begin
              oj <= oj + JW'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  bswg_datapath u_datapath (
    .clk          (clk),
    .ctrl         (ctrl),
    .frac         (frac),
    .weight_value (weight_value)
  );

  // Checks on the sequencer.
  `ASSERT_IMP(a_ready_excl, in_ready, !out_valid, "input ready while results pending")
  `ASSERT_NXT(a_start, in_fire,
    state == ST_MA && k == KW'(MIN_ORDER) && j == JW'(MIN_ORDER - 1), "bad recursion start")
  `ASSERT_NXT(a_run_end, out_fire && last, in_ready, "block not idle after final weight")
  `ASSERT_IMP(a_walk, state == ST_WB, k <= ord && KW'(j) < k, "recursion index out of range")
  `ASSERT_IMP(a_sat, out_valid, weight_value <= OUT_W'(ONE_OUT), "weight above 1.0")

endmodule
